>>> sv/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, widths and codes of the speed profile planner.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

  localparam int unsigned MaxPointsDef = 128;

  localparam int unsigned PosW    = 24;
  localparam int unsigned SpdW    = 16;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned LenW    = 24;
  localparam int unsigned LimW    = 12;
  localparam int unsigned RidxW   = 7;
  localparam int unsigned CntOutW = 8;
  localparam int unsigned StatW   = 3;

  // square root unit: radicand and root widths
  localparam int unsigned RadW  = 2 * (PosW + 1);
  localparam int unsigned RootW = PosW + 1;

  // divider: segment length in Q.8 scaled by 512, speed sum
  localparam int unsigned DivNumW = LenW + 9;
  localparam int unsigned DivDenW = SpdW + 1;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [LimW-1:0] AccelRst = 12'd1395;
  localparam logic [LimW-1:0] DecelRst = 12'd2655;

  localparam logic CfgAccel = 1'b0;
  localparam logic CfgDecel = 1'b1;

  localparam logic [CfgAddrW-1:0] AddrAccel = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrDecel = 3'd4;

  localparam logic KindLoad = 1'b0;
  localparam logic KindRead = 1'b1;

  localparam logic [StatW-1:0] StOk    = 3'd0;
  localparam logic [StatW-1:0] StFew   = 3'd1;
  localparam logic [StatW-1:0] StLost  = 3'd2;
  localparam logic [StatW-1:0] StStall = 3'd3;
  localparam logic [StatW-1:0] StFull  = 3'd4;

  localparam logic [SpdW-1:0]  SpdMax  = '1;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [LenW-1:0]  LenMax  = '1;

  typedef struct packed {
    logic                   kind;
    logic signed [PosW-1:0] point_x;
    logic signed [PosW-1:0] point_y;
    logic [SpdW-1:0]        speed_cap;
    logic [SpdW-1:0]        ego_speed;
    logic                   end_stop;
    logic                   last_point;
    logic [RidxW-1:0]       read_index;
  } spf_in_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [CntOutW-1:0] point_count;
    logic [SpdW-1:0]    speed;
    logic [TimeW-1:0]   eta;
  } spf_out_t;

  typedef enum logic [4:0] {
    OpNone, OpLatch, OpNewPath, OpSetFull, OpLdFirst, OpMulSeg, OpMulFw, OpMulBw,
    OpRootStart, OpLdStore, OpSetFew, OpSetLost, OpSetStall, OpSetOk, OpFwInit,
    OpFwStore, OpStop, OpBwStore, OpTmInit, OpDivStart, OpTmStore, OpResult, OpRdOut
  } spf_op_e;

  typedef enum logic [1:0] {
    RaIdx, RaIdxM1, RaItem
  } spf_ra_e;

  typedef struct packed {
    spf_op_e op;
    spf_ra_e ra;
  } spf_cmd_t;

  typedef struct packed {
    logic is_read;
    logic full;
    logic first;
    logic last;
    logic cnt_lt2;
    logic status_full;
    logic idx_end;
    logic idx_one;
    logic root_done;
    logic div_done;
    logic speed_low;
    logic sum_zero;
    logic out_free;
  } spf_stat_t;

endpackage

`default_nettype wire

>>> sv/spf_sqrt.sv
// ----------------------------------------------------------------------------
// spf_sqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [spf_pkg::RadW-1:0]   rad_i,
  output logic                            done_o,
  output logic [spf_pkg::RootW-1:0]       root_o
);

  localparam int unsigned RemW = spf_pkg::RootW + 2;
  localparam int unsigned CntW = $clog2(spf_pkg::RootW + 1);

  logic [spf_pkg::RadW-1:0]  rad_q;
  logic [RemW-1:0]           rem_q;
  logic [spf_pkg::RootW-1:0] root_q;
  logic [CntW-1:0]           cnt_q;
  logic                      done_q;
  logic [RemW+1:0]           rem_sh;
  logic [RemW+1:0]           trial;
  logic                      ge;

  assign rem_sh = {rem_q, rad_q[spf_pkg::RadW-1 -: 2]};
  assign trial  = (RemW + 2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(spf_pkg::RootW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_q[spf_pkg::RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> sv/spf_div.sv
// ----------------------------------------------------------------------------
// spf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [spf_pkg::DivNumW-1:0]   num_i,
  input  wire logic [spf_pkg::DivDenW-1:0]   den_i,
  output logic                               done_o,
  output logic [spf_pkg::DivNumW-1:0]        quot_o
);

  localparam int unsigned NW   = spf_pkg::DivNumW;
  localparam int unsigned DW   = spf_pkg::DivDenW;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DW-1:0]   den_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [DW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  // dividend bits shift out at the top while quotient bits fill from below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

>>> sv/spf_dp.sv
// ----------------------------------------------------------------------------
// spf_dp
// Datapath: point memories, path registers, multipliers, root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_dp #(
  parameter int unsigned MaxPoints = spf_pkg::MaxPointsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire spf_pkg::spf_in_t           in_item_i,
  input  wire logic [spf_pkg::LimW-1:0]   accel_i,
  input  wire logic [spf_pkg::LimW-1:0]   decel_i,
  input  wire spf_pkg::spf_cmd_t          cmd_i,
  output spf_pkg::spf_stat_t              stat_o,
  output logic                            out_valid_o,
  output spf_pkg::spf_out_t               out_item_o,
  input  wire logic                       out_stall_i
);

  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CW = $clog2(MaxPoints + 1);

  spf_pkg::spf_in_t item_q;
  spf_pkg::spf_out_t out_q;
  logic              out_valid_q;

  logic [CW-1:0]                 cnt_q;
  logic [spf_pkg::StatW-1:0]     status_q;
  logic                          closed_q;
  logic [spf_pkg::SpdW-1:0]      start_q;
  logic signed [spf_pkg::PosW-1:0] prev_x_q;
  logic signed [spf_pkg::PosW-1:0] prev_y_q;
  logic [AW-1:0]                 idx_q;
  logic [spf_pkg::SpdW-1:0]      vrun_q;
  logic [spf_pkg::TimeW-1:0]     eta_q;
  logic [spf_pkg::RadW-1:0]      m0_q;
  logic [spf_pkg::RadW-1:0]      m1_q;

  logic [spf_pkg::LenW-1:0]  seg_mem [MaxPoints];
  logic [spf_pkg::SpdW-1:0]  spd_mem [MaxPoints];
  logic [spf_pkg::TimeW-1:0] eta_mem [MaxPoints];
  logic [spf_pkg::LenW-1:0]  seg_rd_q;
  logic [spf_pkg::SpdW-1:0]  spd_rd_q;
  logic [spf_pkg::TimeW-1:0] eta_rd_q;

  logic [AW-1:0] idx_m1;
  logic [AW-1:0] cnt_addr;
  logic [AW-1:0] ridx_addr;
  logic [AW-1:0] spd_raddr;

  logic                      seg_we;
  logic                      spd_we;
  logic [AW-1:0]             spd_waddr;
  logic [spf_pkg::SpdW-1:0]  spd_wdata;
  logic                      eta_we;
  logic [AW-1:0]             eta_waddr;
  logic [spf_pkg::TimeW-1:0] eta_wdata;

  logic signed [spf_pkg::PosW:0] dx;
  logic signed [spf_pkg::PosW:0] dy;
  logic [spf_pkg::PosW:0]        ax;
  logic [spf_pkg::PosW:0]        ay;
  logic [spf_pkg::RadW-1:0]      sq_x;
  logic [spf_pkg::RadW-1:0]      sq_y;
  logic [2*spf_pkg::SpdW-1:0]    sq_v;
  logic [spf_pkg::LimW-1:0]      lim;
  logic [spf_pkg::LimW+spf_pkg::LenW-1:0] lim_len;
  logic [spf_pkg::RadW-1:0]      radicand;

  logic                          root_done;
  logic [spf_pkg::RootW-1:0]     root;
  logic [spf_pkg::LenW-1:0]      len_sat;
  logic [spf_pkg::SpdW-1:0]      reach_sat;
  logic [spf_pkg::SpdW-1:0]      new_v;

  logic [spf_pkg::DivDenW-1:0]   vsum;
  logic                          div_done;
  logic [spf_pkg::DivNumW-1:0]   quot;
  logic [spf_pkg::DivNumW:0]     t_sum;
  logic [spf_pkg::TimeW-1:0]     eta_new;
  logic                          hit;
  logic                          idx_end;

  // addresses
  assign idx_m1    = idx_q - 1'b1;
  assign cnt_addr  = cnt_q[AW-1:0];
  assign ridx_addr = AW'(item_q.read_index);

  always_comb begin
    unique case (cmd_i.ra)
      spf_pkg::RaIdxM1: spd_raddr = idx_m1;
      spf_pkg::RaItem:  spd_raddr = ridx_addr;
      default:          spd_raddr = idx_q;
    endcase
  end

  // arithmetic
  assign dx   = {item_q.point_x[spf_pkg::PosW-1], item_q.point_x}
              - {prev_x_q[spf_pkg::PosW-1], prev_x_q};
  assign dy   = {item_q.point_y[spf_pkg::PosW-1], item_q.point_y}
              - {prev_y_q[spf_pkg::PosW-1], prev_y_q};
  assign ax   = dx[spf_pkg::PosW] ? (spf_pkg::PosW + 1)'(-dx) : (spf_pkg::PosW + 1)'(dx);
  assign ay   = dy[spf_pkg::PosW] ? (spf_pkg::PosW + 1)'(-dy) : (spf_pkg::PosW + 1)'(dy);
  assign sq_x = ax * ax;
  assign sq_y = ay * ay;
  assign sq_v = vrun_q * vrun_q;
  assign lim  = (cmd_i.op == spf_pkg::OpMulBw) ? decel_i : accel_i;
  assign lim_len  = lim * seg_rd_q;
  assign radicand = m0_q + m1_q;

  spf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == spf_pkg::OpRootStart),
    .rad_i   (radicand),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign len_sat   = root[spf_pkg::RootW-1] ? spf_pkg::LenMax : root[spf_pkg::LenW-1:0];
  assign reach_sat = (|root[spf_pkg::RootW-1:spf_pkg::SpdW]) ? spf_pkg::SpdMax
                                                              : root[spf_pkg::SpdW-1:0];
  assign new_v     = (reach_sat < spd_rd_q) ? reach_sat : spd_rd_q;

  assign vsum = {1'b0, vrun_q} + {1'b0, spd_rd_q};

  spf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == spf_pkg::OpDivStart),
    .num_i   ({seg_rd_q, 9'd0}),
    .den_i   (vsum),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign t_sum   = (spf_pkg::DivNumW + 1)'(eta_q) + (spf_pkg::DivNumW + 1)'(quot);
  assign eta_new = (t_sum > (spf_pkg::DivNumW + 1)'(spf_pkg::TimeMax)) ? spf_pkg::TimeMax
                                                                       : t_sum[spf_pkg::TimeW-1:0];

  assign idx_end = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign hit     = closed_q && (status_q == spf_pkg::StOk)
                && (32'(item_q.read_index) < 32'(cnt_q));

  // memory write ports
  assign seg_we = (cmd_i.op == spf_pkg::OpLdStore);

  always_comb begin
    spd_we    = 1'b0;
    spd_waddr = idx_q;
    spd_wdata = new_v;
    eta_we    = 1'b0;
    eta_waddr = idx_q;
    eta_wdata = eta_new;
    unique case (cmd_i.op)
      spf_pkg::OpLdFirst, spf_pkg::OpLdStore: begin
        spd_we    = 1'b1;
        spd_waddr = cnt_addr;
        spd_wdata = item_q.speed_cap;
      end
      spf_pkg::OpFwInit: begin
        spd_we    = 1'b1;
        spd_waddr = '0;
        spd_wdata = start_q;
      end
      spf_pkg::OpFwStore: begin
        spd_we = 1'b1;
      end
      spf_pkg::OpStop: begin
        spd_we    = item_q.end_stop;
        spd_wdata = '0;
      end
      spf_pkg::OpBwStore: begin
        spd_we    = 1'b1;
        spd_waddr = idx_m1;
      end
      spf_pkg::OpTmInit: begin
        eta_we    = 1'b1;
        eta_waddr = '0;
        eta_wdata = '0;
      end
      spf_pkg::OpTmStore: begin
        eta_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[cnt_addr] <= len_sat;
    end
    if (spd_we) begin
      spd_mem[spd_waddr] <= spd_wdata;
    end
    if (eta_we) begin
      eta_mem[eta_waddr] <= eta_wdata;
    end
    seg_rd_q <= seg_mem[idx_q];
    spd_rd_q <= spd_mem[spd_raddr];
    eta_rd_q <= eta_mem[ridx_addr];
  end

  // path control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      status_q    <= spf_pkg::StOk;
      closed_q    <= 1'b1;
      start_q     <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        spf_pkg::OpNewPath: begin
          if (closed_q) begin
            cnt_q    <= '0;
            status_q <= spf_pkg::StOk;
            closed_q <= 1'b0;
          end
        end
        spf_pkg::OpSetFull:  status_q <= spf_pkg::StFull;
        spf_pkg::OpSetFew:   status_q <= spf_pkg::StFew;
        spf_pkg::OpSetLost:  status_q <= spf_pkg::StLost;
        spf_pkg::OpSetStall: status_q <= spf_pkg::StStall;
        spf_pkg::OpSetOk:    status_q <= spf_pkg::StOk;
        spf_pkg::OpLdFirst: begin
          start_q  <= item_q.ego_speed;
          prev_x_q <= item_q.point_x;
          prev_y_q <= item_q.point_y;
          cnt_q    <= cnt_q + 1'b1;
        end
        spf_pkg::OpLdStore: begin
          prev_x_q <= item_q.point_x;
          prev_y_q <= item_q.point_y;
          cnt_q    <= cnt_q + 1'b1;
        end
        spf_pkg::OpResult: begin
          out_valid_q <= 1'b1;
          closed_q    <= 1'b1;
        end
        spf_pkg::OpRdOut: out_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      spf_pkg::OpLatch: item_q <= in_item_i;
      spf_pkg::OpMulSeg: begin
        m0_q <= sq_x;
        m1_q <= sq_y;
      end
      spf_pkg::OpMulFw, spf_pkg::OpMulBw: begin
        m0_q <= spf_pkg::RadW'(sq_v);
        m1_q <= spf_pkg::RadW'({lim_len, 1'b0});
      end
      spf_pkg::OpFwInit: begin
        vrun_q <= start_q;
        idx_q  <= AW'(1);
      end
      spf_pkg::OpFwStore: begin
        vrun_q <= new_v;
        if (!idx_end) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      spf_pkg::OpStop: begin
        if (item_q.end_stop) begin
          vrun_q <= '0;
        end
      end
      spf_pkg::OpBwStore: begin
        vrun_q <= new_v;
        idx_q  <= idx_m1;
      end
      spf_pkg::OpTmInit: begin
        eta_q  <= '0;
        vrun_q <= start_q;
        idx_q  <= AW'(1);
      end
      spf_pkg::OpTmStore: begin
        eta_q  <= eta_new;
        vrun_q <= spd_rd_q;
        if (!idx_end) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      spf_pkg::OpResult: begin
        out_q.status      <= status_q;
        out_q.point_count <= spf_pkg::CntOutW'(cnt_q);
        out_q.speed       <= '0;
        out_q.eta         <= '0;
      end
      spf_pkg::OpRdOut: begin
        out_q.status      <= status_q;
        out_q.point_count <= spf_pkg::CntOutW'(cnt_q);
        out_q.speed       <= hit ? spd_rd_q : '0;
        out_q.eta         <= hit ? eta_rd_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.is_read     = item_q.kind;
  assign stat_o.full        = cnt_q >= CW'(MaxPoints);
  assign stat_o.first       = cnt_q == '0;
  assign stat_o.last        = item_q.last_point;
  assign stat_o.cnt_lt2     = cnt_q < CW'(2);
  assign stat_o.status_full = status_q == spf_pkg::StFull;
  assign stat_o.idx_end     = idx_end;
  assign stat_o.idx_one     = idx_q == AW'(1);
  assign stat_o.root_done   = root_done;
  assign stat_o.div_done    = div_done;
  assign stat_o.speed_low   = vrun_q < start_q;
  assign stat_o.sum_zero    = vsum == '0;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> sv/spf_ctrl.sv
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer for loading, the forward, backward and time passes, and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire spf_pkg::spf_stat_t  stat_i,
  output spf_pkg::spf_cmd_t        cmd_o,
  output logic                     idle_o
);

  typedef enum logic [4:0] {
    Idle, Dispatch, Load, Root, RootWait, LastCheck, FwRd, FwMul, StopEnd,
    BwRd, BwMul, StartCheck, TmRd, TmSum, TmWait, PlanOk, Result, RdAddr, RdOut
  } state_e;

  typedef enum logic [1:0] {
    PassSeg, PassFwd, PassBwd
  } pass_e;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      pass_q  <= PassSeg;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    cmd_o.op  = spf_pkg::OpNone;
    cmd_o.ra  = spf_pkg::RaIdx;
    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.op = spf_pkg::OpLatch;
          state_d  = Dispatch;
        end
      end
      Dispatch: begin
        if (stat_i.is_read) begin
          state_d = RdAddr;
        end else begin
          cmd_o.op = spf_pkg::OpNewPath;
          state_d  = Load;
        end
      end
      Load: begin
        priority if (stat_i.full) begin
          cmd_o.op = spf_pkg::OpSetFull;
          state_d  = LastCheck;
        end else if (stat_i.first) begin
          cmd_o.op = spf_pkg::OpLdFirst;
          state_d  = LastCheck;
        end else begin
          cmd_o.op = spf_pkg::OpMulSeg;
          pass_d   = PassSeg;
          state_d  = Root;
        end
      end
      Root: begin
        cmd_o.op = spf_pkg::OpRootStart;
        if (pass_q == PassBwd) begin
          cmd_o.ra = spf_pkg::RaIdxM1;
        end
        state_d = RootWait;
      end
      RootWait: begin
        if (pass_q == PassBwd) begin
          cmd_o.ra = spf_pkg::RaIdxM1;
        end
        if (stat_i.root_done) begin
          unique case (pass_q)
            PassFwd: begin
              cmd_o.op = spf_pkg::OpFwStore;
              state_d  = stat_i.idx_end ? StopEnd : FwRd;
            end
            PassBwd: begin
              cmd_o.op = spf_pkg::OpBwStore;
              state_d  = stat_i.idx_one ? StartCheck : BwRd;
            end
            default: begin
              cmd_o.op = spf_pkg::OpLdStore;
              state_d  = LastCheck;
            end
          endcase
        end
      end
      LastCheck: begin
        priority if (!stat_i.last) begin
          state_d = Idle;
        end else if (stat_i.status_full) begin
          state_d = Result;
        end else if (stat_i.cnt_lt2) begin
          cmd_o.op = spf_pkg::OpSetFew;
          state_d  = Result;
        end else begin
          cmd_o.op = spf_pkg::OpFwInit;
          state_d  = FwRd;
        end
      end
      FwRd: state_d = FwMul;
      FwMul: begin
        cmd_o.op = spf_pkg::OpMulFw;
        pass_d   = PassFwd;
        state_d  = Root;
      end
      StopEnd: begin
        cmd_o.op = spf_pkg::OpStop;
        state_d  = BwRd;
      end
      BwRd: begin
        cmd_o.ra = spf_pkg::RaIdxM1;
        state_d  = BwMul;
      end
      BwMul: begin
        cmd_o.ra = spf_pkg::RaIdxM1;
        cmd_o.op = spf_pkg::OpMulBw;
        pass_d   = PassBwd;
        state_d  = Root;
      end
      StartCheck: begin
        if (stat_i.speed_low) begin
          cmd_o.op = spf_pkg::OpSetLost;
          state_d  = Result;
        end else begin
          cmd_o.op = spf_pkg::OpTmInit;
          state_d  = TmRd;
        end
      end
      TmRd: state_d = TmSum;
      TmSum: begin
        if (stat_i.sum_zero) begin
          cmd_o.op = spf_pkg::OpSetStall;
          state_d  = Result;
        end else begin
          cmd_o.op = spf_pkg::OpDivStart;
          state_d  = TmWait;
        end
      end
      TmWait: begin
        if (stat_i.div_done) begin
          cmd_o.op = spf_pkg::OpTmStore;
          state_d  = stat_i.idx_end ? PlanOk : TmRd;
        end
      end
      PlanOk: begin
        cmd_o.op = spf_pkg::OpSetOk;
        state_d  = Result;
      end
      Result: begin
        if (stat_i.out_free) begin
          cmd_o.op = spf_pkg::OpResult;
          state_d  = Idle;
        end
      end
      RdAddr: begin
        cmd_o.ra = spf_pkg::RaItem;
        state_d  = RdOut;
      end
      RdOut: begin
        cmd_o.ra = spf_pkg::RaItem;
        if (stat_i.out_free) begin
          cmd_o.op = spf_pkg::OpRdOut;
          state_d  = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  assign idle_o = (state_q == Idle);

endmodule

`default_nettype wire

>>> sv/speed_profile_forward_backward.sv
// ----------------------------------------------------------------------------
// speed_profile_forward_backward
// Forward/backward speed profile planner over a loaded path of points.
// ----------------------------------------------------------------------------
// Input items (valid/stall) either load one path point or read one planned
// point; output items (valid/stall) carry status, point count, speed and eta.
// Limits are to be written over the APB port while the block is idle; the
// user keeps to this, as the block has no guard for it. One item is worked
// at a time; in_stall_o is high until it is finished. A read fetches its
// entry and then offers its result; the first load of a path stores its
// point directly, and later loads that fit each take one square root for
// their segment length. The point marked last then runs the plan: a forward
// and a backward pass, both through the shared square root unit, and a time
// pass through the divider, before its result is offered.
// A waiting result sits in the output register; the next item is taken
// meanwhile and only an item with a result of its own waits for it to go.
// Reset clears the path (count, status, start speed, last position) and
// loads the default limits; the point memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_profile_forward_backward #(
  parameter int unsigned MaxPoints = spf_pkg::MaxPointsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire spf_pkg::spf_in_t              in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output spf_pkg::spf_out_t                  out_item_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spf_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [spf_pkg::CfgDataW-1:0]  pwdata,
  output logic [spf_pkg::CfgDataW-1:0]       prdata,
  output logic                               pready
);

  logic [spf_pkg::LimW-1:0] accel_q;
  logic [spf_pkg::LimW-1:0] decel_q;
  logic                     cfg_wr;
  logic                     idle;
  spf_pkg::spf_cmd_t        cmd;
  spf_pkg::spf_stat_t       stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= spf_pkg::AccelRst;
      decel_q <= spf_pkg::DecelRst;
    end else if (cfg_wr) begin
      if (paddr[2] == spf_pkg::CfgDecel) begin
        decel_q <= pwdata[spf_pkg::LimW-1:0];
      end else begin
        accel_q <= pwdata[spf_pkg::LimW-1:0];
      end
    end
  end

  // misaligned addresses read as zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      prdata = (paddr[2] == spf_pkg::CfgDecel) ? spf_pkg::CfgDataW'(decel_q)
                                               : spf_pkg::CfgDataW'(accel_q);
    end
  end

  assign in_stall_o = !idle;

  spf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  spf_dp #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .accel_i     (accel_q),
    .decel_i     (decel_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

>>> dv/spf_profile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_profile_checker
// Watches the item channels and the APB port of the speed profile planner,
// predicts every result from its own copy of the path and limits, and compares
// each delivered result field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module spf_profile_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire spf_pkg::spf_in_t             in_item_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire spf_pkg::spf_out_t            out_item_i,
  input  wire logic                         psel_i,
  input  wire logic                         penable_i,
  input  wire logic                         pwrite_i,
  input  wire logic                         pready_i,
  input  wire logic [spf_pkg::CfgAddrW-1:0] paddr_i,
  input  wire logic [spf_pkg::CfgDataW-1:0] pwdata_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int unsigned Depth = spf_pkg::MaxPointsDef;

  logic [spf_pkg::LenW-1:0]  seg_len  [Depth];
  logic [spf_pkg::SpdW-1:0]  plan_spd [Depth];
  logic [spf_pkg::TimeW-1:0] plan_eta [Depth];
  int unsigned                      n_loaded;
  logic signed [spf_pkg::PosW-1:0]  last_x, last_y;
  logic [spf_pkg::SpdW-1:0]         v_start;
  logic [spf_pkg::StatW-1:0]        path_stat;
  bit                               closed;
  logic [spf_pkg::LimW-1:0]         acc_lim, dec_lim;
  spf_pkg::spf_out_t                expected_results [$];

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [spf_pkg::SpdW-1:0] reachable(logic [spf_pkg::SpdW-1:0] v,
                                                         logic [spf_pkg::LimW-1:0] lim,
                                                         logic [spf_pkg::LenW-1:0] len);
    longint unsigned s, r;
    s = 64'(v) * 64'(v) + 64'd2 * 64'(lim) * 64'(len);
    r = int_root(s);
    return (r > 64'(spf_pkg::SpdMax)) ? spf_pkg::SpdMax : r[spf_pkg::SpdW-1:0];
  endfunction

  function automatic void plan_profile(bit stop);
    int unsigned n;
    logic [spf_pkg::SpdW-1:0] r;
    longint unsigned t, s;
    n = n_loaded;
    if (path_stat == spf_pkg::StFull) return;
    if (n < 2) begin
      path_stat = spf_pkg::StFew;
      return;
    end
    plan_spd[0] = v_start;
    for (int i = 1; i < n; i++) begin
      r = reachable(plan_spd[i-1], acc_lim, seg_len[i]);
      if (r < plan_spd[i]) plan_spd[i] = r;
    end
    if (stop) plan_spd[n-1] = '0;
    for (int i = n - 1; i > 0; i--) begin
      r = reachable(plan_spd[i], dec_lim, seg_len[i]);
      if (r < plan_spd[i-1]) plan_spd[i-1] = r;
    end
    if (plan_spd[0] < v_start) begin
      path_stat = spf_pkg::StLost;
      return;
    end
    plan_spd[0] = v_start;
    plan_eta[0] = '0;
    for (int i = 1; i < n; i++) begin
      s = 64'(plan_spd[i-1]) + 64'(plan_spd[i]);
      if (s == 0) begin
        path_stat = spf_pkg::StStall;
        return;
      end
      t = 64'(plan_eta[i-1]) + (64'(seg_len[i]) * 64'd512) / s;
      plan_eta[i] = (t > 64'(spf_pkg::TimeMax)) ? spf_pkg::TimeMax : t[spf_pkg::TimeW-1:0];
    end
    path_stat = spf_pkg::StOk;
  endfunction

  function automatic void predict_item(spf_pkg::spf_in_t it);
    spf_pkg::spf_out_t o;
    longint dx, dy;
    longint unsigned ax, ay, len;
    int unsigned k;
    o = '0;
    if (it.kind == spf_pkg::KindRead) begin
      o.status = path_stat;
      o.point_count = n_loaded[spf_pkg::CntOutW-1:0];
      if (closed && path_stat == spf_pkg::StOk && it.read_index < n_loaded) begin
        o.speed = plan_spd[it.read_index];
        o.eta = plan_eta[it.read_index];
      end
      expected_results.insert(expected_results.size(), o);
      return;
    end
    // a load after a closed path starts a new one
    if (closed) begin
      n_loaded = 0;
      path_stat = spf_pkg::StOk;
      closed = 0;
    end
    if (n_loaded >= Depth) begin
      path_stat = spf_pkg::StFull;
    end else begin
      k = n_loaded;
      if (k == 0) begin
        v_start = it.ego_speed;
        seg_len[0] = '0;
      end else begin
        dx = longint'(it.point_x) - longint'(last_x);
        dy = longint'(it.point_y) - longint'(last_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        len = int_root(ax * ax + ay * ay);
        seg_len[k] = (len > 64'(spf_pkg::LenMax)) ? spf_pkg::LenMax : len[spf_pkg::LenW-1:0];
      end
      plan_spd[k] = it.speed_cap;
      last_x = it.point_x;
      last_y = it.point_y;
      n_loaded = k + 1;
    end
    if (!it.last_point) return;
    plan_profile(it.end_stop);
    closed = 1;
    o.status = path_stat;
    o.point_count = n_loaded[spf_pkg::CntOutW-1:0];
    expected_results.insert(expected_results.size(), o);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    spf_pkg::spf_out_t want;
    if (!rst_ni) begin
      n_loaded = 0;
      last_x = '0;
      last_y = '0;
      v_start = '0;
      path_stat = spf_pkg::StOk;
      closed = 1;
      acc_lim = spf_pkg::AccelRst;
      dec_lim = spf_pkg::DecelRst;
      expected_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          spf_pkg::AddrAccel: acc_lim = pwdata_i[spf_pkg::LimW-1:0];
          spf_pkg::AddrDecel: dec_lim = pwdata_i[spf_pkg::LimW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("result items in hand", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.status !== want.status)
            report("status", out_item_i.status, want.status);
          if (out_item_i.point_count !== want.point_count)
            report("point_count", out_item_i.point_count, want.point_count);
          if (out_item_i.speed !== want.speed)
            report("speed", out_item_i.speed, want.speed);
          if (out_item_i.eta !== want.eta)
            report("eta", out_item_i.eta, want.eta);
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(in_item_i);
    end
    pending_o = expected_results.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the speed profile planner: directed paths for
// the status cases and extremes, then random paths, reads and limit settings
// with random gaps on both channels; checking sits in spf_profile_checker.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned ItemTarget = 1050;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spf_pkg::spf_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spf_pkg::spf_out_t out_item;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [spf_pkg::CfgAddrW-1:0] paddr = '0;
  logic [spf_pkg::CfgDataW-1:0] pwdata = '0;
  logic [spf_pkg::CfgDataW-1:0] prdata;
  logic pready;
  int fail_count, pending;
  int unsigned cycles = 0, items = 0, paths = 0, reads = 0, settings = 0;
  bit quiet = 0;
  logic signed [spf_pkg::PosW-1:0] cur_x = '0, cur_y = '0;

  speed_profile_forward_backward dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spf_profile_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL speed_profile_forward_backward");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall <= !quiet && ($urandom_range(99) < 13);

  function automatic spf_pkg::spf_in_t rand_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(spf_pkg::spf_in_t)-1:0];
  endfunction

  task automatic send_item(spf_pkg::spf_in_t it);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (in_stall);
    items++;
  endtask

  task automatic load_pt(logic signed [spf_pkg::PosW-1:0] x,
                         logic signed [spf_pkg::PosW-1:0] y,
                         logic [spf_pkg::SpdW-1:0] cap, logic [spf_pkg::SpdW-1:0] ego,
                         bit stop, bit last);
    spf_pkg::spf_in_t it;
    it = rand_item();
    it.kind = spf_pkg::KindLoad;
    it.point_x = x;
    it.point_y = y;
    it.speed_cap = cap;
    it.ego_speed = ego;
    it.end_stop = stop;
    it.last_point = last;
    cur_x = x;
    cur_y = y;
    if (last) paths++;
    send_item(it);
  endtask

  task automatic read_pt(logic [spf_pkg::RidxW-1:0] idx);
    spf_pkg::spf_in_t it;
    it = rand_item();
    it.kind = spf_pkg::KindRead;
    it.read_index = idx;
    reads++;
    send_item(it);
  endtask

  // wait until the block has nothing left in hand
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [spf_pkg::CfgAddrW-1:0] addr,
                           logic [spf_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(logic [spf_pkg::LimW-1:0] acc, logic [spf_pkg::LimW-1:0] dec);
    settle();
    apb_write(spf_pkg::AddrAccel, {$urandom} & ~32'hFFF | acc);
    apb_write(spf_pkg::AddrDecel, {$urandom} & ~32'hFFF | dec);
    settings++;
  endtask

  function automatic logic [spf_pkg::SpdW-1:0] rand_cap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return spf_pkg::SpdMax;
    if (r < 40) return spf_pkg::SpdW'($urandom);
    if (r < 45) return '0;
    return spf_pkg::SpdW'($urandom_range(0, 8000));
  endfunction

  task automatic random_path(int unsigned n, bit noisy);
    logic signed [spf_pkg::PosW-1:0] x, y;
    logic [spf_pkg::SpdW-1:0] ego;
    ego = ($urandom_range(9) == 0) ? spf_pkg::SpdW'($urandom)
                                   : spf_pkg::SpdW'($urandom_range(0, 6000));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        x = spf_pkg::PosW'($urandom);
        y = spf_pkg::PosW'($urandom);
      end else begin
        x = cur_x + spf_pkg::PosW'($urandom_range(0, 8191)) - spf_pkg::PosW'(4096);
        y = cur_y + spf_pkg::PosW'($urandom_range(0, 8191)) - spf_pkg::PosW'(4096);
      end
      // read in the middle of loading
      if (noisy && $urandom_range(3) == 0) read_pt(spf_pkg::RidxW'($urandom_range(0, n)));
      load_pt(x, y, rand_cap(), ego, 1'($urandom_range(1)), i == n - 1);
    end
    repeat ($urandom_range(1, 4))
      read_pt(($urandom_range(7) == 0) ? spf_pkg::RidxW'($urandom)
                                       : spf_pkg::RidxW'($urandom_range(0, n)));
  endtask

  initial begin
    int unsigned next_cfg;
    bit big_done, over_done;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // read before any path
    read_pt('0);
    // single point closes as too few, at the position and speed extremes
    load_pt(-24'sd8388608, 24'sd8388607, '0, spf_pkg::SpdMax, 1'b1, 1'b1);
    read_pt('0);
    // widest jump saturates the segment length
    load_pt(-24'sd8388608, -24'sd8388608, spf_pkg::SpdMax, spf_pkg::SpdMax, 1'b0, 1'b0);
    load_pt(24'sd8388607, 24'sd8388607, spf_pkg::SpdMax, spf_pkg::SpdMax, 1'b0, 1'b1);
    read_pt(7'd0);
    read_pt(7'd1);
    read_pt(7'd127);
    // standing start with zero cap stalls the time pass
    load_pt('0, '0, spf_pkg::SpdMax, '0, 1'b0, 1'b0);
    load_pt(24'sd256, '0, '0, '0, 1'b0, 1'b1);
    read_pt(7'd1);
    // fast start and stop after one metre loses the start speed
    load_pt('0, '0, spf_pkg::SpdMax, 16'd5000, 1'b0, 1'b0);
    load_pt('0, 24'sd256, spf_pkg::SpdMax, '0, 1'b1, 1'b1);
    read_pt(7'd0);
    // read while loading, then a normal stopping path
    load_pt('0, '0, 16'd3000, 16'd512, 1'b0, 1'b0);
    read_pt(7'd0);
    load_pt(24'sd2560, 24'sd1280, 16'd4000, 16'd0, 1'b0, 1'b0);
    load_pt(24'sd5120, 24'sd2560, spf_pkg::SpdMax, 16'd0, 1'b1, 1'b1);
    read_pt(7'd0);
    read_pt(7'd1);
    read_pt(7'd2);
    read_pt(7'd3);

    next_cfg = items;
    big_done = 0;
    over_done = 0;
    while (items < ItemTarget) begin
      quiet = (items >= 450 && items < 600);
      if (items >= next_cfg) begin
        case ($urandom_range(5))
          0: set_limits(12'd1, 12'd4095);
          1: set_limits(12'd4095, 12'd1);
          2: set_limits(12'd4095, 12'd4095);
          3: set_limits(12'd1, 12'd1);
          4: set_limits('0, '0);
          default: set_limits(spf_pkg::LimW'($urandom_range(1, 4095)),
                              spf_pkg::LimW'($urandom_range(1, 4095)));
        endcase
        next_cfg = items + $urandom_range(80, 160);
      end
      if (!big_done && items >= 300) begin
        random_path(spf_pkg::MaxPointsDef, 0);
        big_done = 1;
      end else if (!over_done && items >= 700) begin
        random_path(spf_pkg::MaxPointsDef + 3, 0);
        over_done = 1;
      end else begin
        case ($urandom_range(19))
          0: read_pt(spf_pkg::RidxW'($urandom));
          1: random_path(1, 0);
          2: random_path($urandom_range(2, 6), 1);
          3: random_path($urandom_range(9, 20), 0);
          default: random_path($urandom_range(2, 8), 0);
        endcase
      end
    end
    quiet = 0;
    set_limits(spf_pkg::AccelRst, spf_pkg::DecelRst);
    random_path(4, 0);

    settle();
    $display("covered %0d items: %0d paths closed, %0d reads, %0d limit settings",
             items, paths, reads, settings);
    if (fail_count == 0) begin
      $display("PASS speed_profile_forward_backward");
    end else begin
      $display("FAIL speed_profile_forward_backward");
    end
    $finish;
  end

endmodule
